FILE: rtl/core/rgbc_pkg.sv
// Shared types, codes and arithmetic helpers for the RGB 3x3 convolution block.
`timescale 1ns / 1ps
package rgbc_pkg;

	localparam int PIX_W  = 32;
	localparam int LINE_W = 64;
	localparam int ACC_W  = 16;
	localparam int PROD_W = 25;
	localparam int NUM_W  = 30;

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic [2:0] CFG_WIDTH   = 3'd0;
	localparam logic [2:0] CFG_HEIGHT  = 3'd1;
	localparam logic [2:0] CFG_KTOP    = 3'd2;
	localparam logic [2:0] CFG_KMIDDLE = 3'd3;
	localparam logic [2:0] CFG_KBOTTOM = 3'd4;

	typedef enum logic [2:0] {
		S_PUSH  = 3'b001,
		S_FETCH = 3'b010,
		S_DRAIN = 3'b100
	} conv_state_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// add one weighted tap, truncating the integer sum toward zero
	function automatic acc_t tap_step(input acc_t acc, input prod_t prod);
		logic signed [NUM_W-1:0] num;
		logic signed [NUM_W-1:0] quo;
		num = ($signed({{(NUM_W-ACC_W-12){acc[ACC_W-1]}}, acc, 12'b0}))
			+ NUM_W'(prod);
		quo = num >>> 12;
		if (num[NUM_W-1] && (num[11:0] != 12'b0)) begin
			quo = quo + NUM_W'(1);
		end
		return quo[ACC_W-1:0];
	endfunction

	function automatic logic [7:0] sat8(input acc_t acc);
		logic [7:0] res;
		if (acc[ACC_W-1]) begin
			res = 8'd0;
		end else if (acc > acc_t'(255)) begin
			res = 8'd255;
		end else begin
			res = acc[7:0];
		end
		return res;
	endfunction

endpackage

FILE: rtl/core/rgbc_if.sv
// Request channel interfaces for pixels in and filtered pixels out.
`timescale 1ns / 1ps
interface rgbc_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	logic [7:0] in_alpha;

	modport source(output valid, operation, in_red, in_green, in_blue, in_alpha,
		input ready);
	modport sink(input valid, operation, in_red, in_green, in_blue, in_alpha,
		output ready);
endinterface

interface rgbc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic       frame_end;

	modport source(output valid, out_red, out_green, out_blue, out_alpha, frame_end,
		input ready);
	modport sink(input valid, out_red, out_green, out_blue, out_alpha, frame_end,
		output ready);
endinterface

FILE: rtl/core/rgb_conv3x3_replicate_edge.sv
// Top level: 3x3 RGB convolution with replicated border on a raster pixel stream.
// Each result passes the stage registers s1, s2, s3 and then the output register.
// Throughput: one request per cycle while the output is not stalled; the last pixel
// of a row with a row above and a pixel to its left gives two results and holds off
// the next request, and after the frame's last pixel a fetch state reads the line memory before drains are taken.
// Reset clears counters, window and pipeline; the line memories are not cleared.
`timescale 1ns / 1ps
module rgb_conv3x3_replicate_edge #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [47:0]   cfg_data,
	rgbc_in_if.sink       pix_in,
	rgbc_out_if.source    pix_out
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);

	logic [10:0] width_q, height_q;
	logic [47:0] kern_q [3];

	logic [31:0]   w32, h32;
	logic [CW-1:0] weff;
	logic [RW-1:0] heff;

	rgbc_pkg::conv_state_t state_q, state_d;
	logic [CW-1:0] col_q, col_d, drain_q, drain_d;
	logic [RW-1:0] row_q, row_d;
	logic          pend_q, pend_d;

	rgbc_pkg::pix_t win_q [9];
	rgbc_pkg::pix_t win_d [9];
	logic [rgbc_pkg::LINE_W-1:0] dl_q, dc_q, rdata;

	logic adv, accept, push_go, drain_go, last_col, dr_last;
	rgbc_pkg::pix_t cur, up, mid;
	logic [AW-1:0] raddr;

	logic inj;
	rgbc_pkg::pix_t sel [9];
	logic sel_last;
	logic signed [15:0] coef [9];

	logic                v_s1, v_s2, v_s3;
	rgbc_pkg::prod_t     prod_s1 [3][9];
	rgbc_pkg::prod_t     prod_s2 [3][6];
	rgbc_pkg::prod_t     prod_s3 [3][3];
	rgbc_pkg::acc_t      acc_s2 [3];
	rgbc_pkg::acc_t      acc_s3 [3];
	logic [7:0]          alpha_s1, alpha_s2, alpha_s3;
	logic                last_s1, last_s2, last_s3;

	logic       out_valid_q;
	logic [7:0] red_q, green_q, blue_q, alpha_q;
	logic       fend_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 11'd1024;
			height_q  <= 11'd1024;
			kern_q[0] <= 48'h0;
			kern_q[1] <= 48'h0000_1000_0000;
			kern_q[2] <= 48'h0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rgbc_pkg::CFG_WIDTH:   width_q   <= cfg_data[10:0];
				rgbc_pkg::CFG_HEIGHT:  height_q  <= cfg_data[10:0];
				rgbc_pkg::CFG_KTOP:    kern_q[0] <= cfg_data;
				rgbc_pkg::CFG_KMIDDLE: kern_q[1] <= cfg_data;
				rgbc_pkg::CFG_KBOTTOM: kern_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == 11'd0) begin
			w32 = 32'd1;
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w32 = 32'(MAX_WIDTH);
		end else begin
			w32 = 32'(width_q);
		end
		if (height_q == 11'd0) begin
			h32 = 32'd1;
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h32 = 32'(MAX_HEIGHT);
		end else begin
			h32 = 32'(height_q);
		end
	end
	assign weff = w32[CW-1:0];
	assign heff = h32[RW-1:0];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int l = 0; l < 3; l++) begin
				coef[k*3+l] = kern_q[k][16*l +: 16];
			end
		end
	end

	// handshake and control
	assign adv          = !out_valid_q || pix_out.ready;
	assign pix_in.ready = adv && !pend_q && (state_q != rgbc_pkg::S_FETCH);
	assign accept       = pix_in.valid && pix_in.ready;
	assign push_go  = accept && (pix_in.operation == rgbc_pkg::OP_PUSH)
		&& (state_q == rgbc_pkg::S_PUSH);
	assign drain_go = accept && (pix_in.operation == rgbc_pkg::OP_DRAIN)
		&& (state_q == rgbc_pkg::S_DRAIN);
	assign last_col = ((CW+1)'(col_q) + (CW+1)'(1)) >= (CW+1)'(weff);
	assign dr_last  = ((CW+1)'(drain_q) + (CW+1)'(1)) >= (CW+1)'(weff);

	assign cur = {pix_in.in_alpha, pix_in.in_blue, pix_in.in_green, pix_in.in_red};
	assign up  = (row_q == '0) ? cur : rdata[31:0];
	assign mid = (row_q == '0) ? cur : rdata[63:32];

	always_comb begin
		state_d = state_q;
		col_d   = col_q;
		row_d   = row_q;
		drain_d = drain_q;
		priority if (state_q == rgbc_pkg::S_FETCH) begin
			state_d = rgbc_pkg::S_DRAIN;
		end else if (push_go) begin
			if (last_col) begin
				col_d = '0;
				row_d = row_q + RW'(1);
				if (((RW+1)'(row_q) + (RW+1)'(1)) >= (RW+1)'(heff)) begin
					state_d = rgbc_pkg::S_FETCH;
				end
			end else begin
				col_d = col_q + CW'(1);
			end
		end else if (drain_go) begin
			if (dr_last) begin
				state_d = rgbc_pkg::S_PUSH;
				col_d   = '0;
				row_d   = '0;
				drain_d = '0;
			end else begin
				drain_d = drain_q + CW'(1);
			end
		end else begin
		end
	end

	always_comb begin
		unique case (state_d)
			rgbc_pkg::S_PUSH:  raddr = col_d[AW-1:0];
			rgbc_pkg::S_FETCH: raddr = '0;
			rgbc_pkg::S_DRAIN: raddr = drain_d[AW-1:0] + AW'(1);
			default:           raddr = '0;
		endcase
	end

	rgbc_linebuf #(
		.DEPTH(MAX_WIDTH),
		.AW   (AW)
	) u_linebuf (
		.clk  (clk),
		.we   (push_go),
		.waddr(col_q[AW-1:0]),
		.wdata({cur, mid}),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_d[k*3]   = win_q[k*3+1];
			win_d[k*3+1] = win_q[k*3+2];
		end
		win_d[2] = up;
		win_d[5] = mid;
		win_d[8] = cur;
	end

	// choose the nine pixels of the next result
	always_comb begin
		inj      = 1'b0;
		sel_last = 1'b0;
		pend_d   = pend_q;
		for (int t = 0; t < 9; t++) begin
			sel[t] = win_d[t];
		end
		priority if (pend_q) begin
			inj = 1'b1;
			pend_d = !adv;
			for (int k = 0; k < 3; k++) begin
				sel[k*3]   = win_q[k*3+1];
				sel[k*3+1] = win_q[k*3+2];
				sel[k*3+2] = win_q[k*3+2];
			end
		end else if (push_go && (row_q != '0) && (col_q != '0)) begin
			inj = 1'b1;
			pend_d = last_col;
			for (int k = 0; k < 3; k++) begin
				sel[k*3] = (col_q >= CW'(2)) ? win_d[k*3] : win_d[k*3+1];
			end
		end else if (push_go && (row_q != '0) && last_col) begin
			inj = 1'b1;
			for (int k = 0; k < 3; k++) begin
				sel[k*3]   = win_d[k*3+2];
				sel[k*3+1] = win_d[k*3+2];
			end
		end else if (drain_go) begin
			inj      = 1'b1;
			sel_last = dr_last;
			sel[0] = (drain_q != '0) ? dl_q[31:0] : dc_q[31:0];
			sel[1] = dc_q[31:0];
			sel[2] = dr_last ? dc_q[31:0] : rdata[31:0];
			sel[3] = (drain_q != '0) ? dl_q[63:32] : dc_q[63:32];
			sel[4] = dc_q[63:32];
			sel[5] = dr_last ? dc_q[63:32] : rdata[63:32];
			sel[6] = sel[3];
			sel[7] = sel[4];
			sel[8] = sel[5];
		end else begin
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgbc_pkg::S_PUSH;
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
			pend_q  <= 1'b0;
			for (int t = 0; t < 9; t++) begin
				win_q[t] <= '0;
			end
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			drain_q <= drain_d;
			pend_q  <= pend_d;
			if (push_go) begin
				for (int t = 0; t < 9; t++) begin
					win_q[t] <= win_d[t];
				end
			end
		end
	end

	// drain columns: left and centre held, right from memory (centre repeated at the last column)
	always_ff @(posedge clk) begin
		if (state_q == rgbc_pkg::S_FETCH) begin
			dc_q <= rdata;
		end else if (drain_go) begin
			dl_q <= dc_q;
			dc_q <= rdata;
		end
	end

	// arithmetic pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= inj;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ch = 0; ch < 3; ch++) begin
				for (int t = 0; t < 9; t++) begin
					prod_s1[ch][t] <=
						rgbc_pkg::PROD_W'($signed({1'b0, sel[t][8*ch +: 8]}))
						* rgbc_pkg::PROD_W'(coef[t]);
				end
			end
			alpha_s1 <= sel[4][31:24];
			last_s1  <= sel_last;

			for (int ch = 0; ch < 3; ch++) begin
				acc_s2[ch] <= rgbc_pkg::tap_step(rgbc_pkg::tap_step(
					rgbc_pkg::tap_step('0, prod_s1[ch][0]),
					prod_s1[ch][1]), prod_s1[ch][2]);
				for (int t = 0; t < 6; t++) begin
					prod_s2[ch][t] <= prod_s1[ch][t+3];
				end
			end
			alpha_s2 <= alpha_s1;
			last_s2  <= last_s1;

			for (int ch = 0; ch < 3; ch++) begin
				acc_s3[ch] <= rgbc_pkg::tap_step(rgbc_pkg::tap_step(
					rgbc_pkg::tap_step(acc_s2[ch], prod_s2[ch][0]),
					prod_s2[ch][1]), prod_s2[ch][2]);
				for (int t = 0; t < 3; t++) begin
					prod_s3[ch][t] <= prod_s2[ch][t+3];
				end
			end
			alpha_s3 <= alpha_s2;
			last_s3  <= last_s2;

			red_q   <= rgbc_pkg::sat8(rgbc_pkg::tap_step(rgbc_pkg::tap_step(
				rgbc_pkg::tap_step(acc_s3[0], prod_s3[0][0]),
				prod_s3[0][1]), prod_s3[0][2]));
			green_q <= rgbc_pkg::sat8(rgbc_pkg::tap_step(rgbc_pkg::tap_step(
				rgbc_pkg::tap_step(acc_s3[1], prod_s3[1][0]),
				prod_s3[1][1]), prod_s3[1][2]));
			blue_q  <= rgbc_pkg::sat8(rgbc_pkg::tap_step(rgbc_pkg::tap_step(
				rgbc_pkg::tap_step(acc_s3[2], prod_s3[2][0]),
				prod_s3[2][1]), prod_s3[2][2]));
			alpha_q <= alpha_s3;
			fend_q  <= last_s3;
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.out_red   = red_q;
	assign pix_out.out_green = green_q;
	assign pix_out.out_blue  = blue_q;
	assign pix_out.out_alpha = alpha_q;
	assign pix_out.frame_end = fend_q;

`ifndef SYNTHESIS
	a_fetch_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rgbc_pkg::S_FETCH) |-> !pix_in.ready)
		else $error("request taken during line memory fetch");
	a_fetch_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rgbc_pkg::S_FETCH) |=> (state_q == rgbc_pkg::S_DRAIN))
		else $error("fetch did not hand over to drain");
	a_pend_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && adv) |=> !pend_q)
		else $error("second result not issued");
`endif

endmodule

FILE: rtl/core/rgbc_linebuf.sv
// Line memory holding the upper and middle rows, one write and one registered read.
`timescale 1ns / 1ps
module rgbc_linebuf #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [rgbc_pkg::LINE_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [rgbc_pkg::LINE_W-1:0] rdata
);

	logic [rgbc_pkg::LINE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: tb/rgb_conv3x3_replicate_edge_tb.sv
// Testbench for the 3x3 RGB convolution: random frames against an in-bench pixel predictor.
`timescale 1ns / 1ps
module rgb_conv3x3_replicate_edge_tb;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       frame_end;
	} filt_pix_t;

	class conv_scoreboard;
		logic [31:0] upper_row[1024];
		logic [31:0] middle_row[1024];
		logic [31:0] win[9];
		int unsigned row_cnt, col_cnt, drain_cnt;
		int unsigned width_reg, height_reg;
		logic [47:0] kern[3];
		filt_pix_t expected_pix[$];
		int unsigned mismatches;

		function void reset_state();
			foreach (win[i]) win[i] = '0;
			row_cnt = 0;
			col_cnt = 0;
			drain_cnt = 0;
			width_reg = 1024;
			height_reg = 1024;
			kern[0] = '0;
			kern[1] = 48'd268435456;
			kern[2] = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [47:0] val);
			case (idx)
				rgbc_pkg::CFG_WIDTH: begin
					width_reg = val[10:0];
				end
				rgbc_pkg::CFG_HEIGHT: begin
					height_reg = val[10:0];
				end
				rgbc_pkg::CFG_KTOP: begin
					kern[0] = val;
				end
				rgbc_pkg::CFG_KMIDDLE: begin
					kern[1] = val;
				end
				rgbc_pkg::CFG_KBOTTOM: begin
					kern[2] = val;
				end
				default: begin
				end
			endcase
		endfunction

		function filt_pix_t convolve(logic [31:0] p[9], bit last);
			filt_pix_t res;
			longint acc;
			longint q;
			longint pix;
			for (int ch = 0; ch < 3; ch++) begin
				acc = 0;
				for (int t = 0; t < 9; t++) begin
					pix = p[t][8*ch +: 8];
					q = longint'($signed(kern[t/3][16*(t%3) +: 16]));
					acc = (acc * 4096 + pix * q) / 4096;
				end
				if (acc < 0) acc = 0;
				if (acc > 255) acc = 255;
				case (ch)
					0: res.red = acc[7:0];
					1: res.green = acc[7:0];
					default: res.blue = acc[7:0];
				endcase
			end
			res.alpha = p[4][31:24];
			res.frame_end = last;
			return res;
		endfunction

		function void from_window(int a, int b, int c);
			logic [31:0] p[9];
			for (int k = 0; k < 3; k++) begin
				p[k*3]   = win[k*3+a];
				p[k*3+1] = win[k*3+b];
				p[k*3+2] = win[k*3+c];
			end
			expected_pix.push_back(convolve(p, 1'b0));
		endfunction

		function void note_request(logic op, logic [7:0] r, logic [7:0] g,
				logic [7:0] b, logic [7:0] a);
			int unsigned w, h, c, k, l, rr;
			logic [31:0] cur, up, mid;
			logic [31:0] p[9];
			bit last;
			w = (width_reg == 0) ? 1 : (width_reg > 1024 ? 1024 : width_reg);
			h = (height_reg == 0) ? 1 : (height_reg > 1024 ? 1024 : height_reg);
			if (op == rgbc_pkg::OP_PUSH) begin
				if (row_cnt >= h) return;
				c = col_cnt % 1024;
				cur = {a, b, g, r};
				if (row_cnt == 0) begin
					up = cur;
					mid = cur;
				end else begin
					up = upper_row[c];
					mid = middle_row[c];
				end
				upper_row[c] = (row_cnt == 0) ? cur : mid;
				middle_row[c] = cur;
				for (int k2 = 0; k2 < 3; k2++) begin
					win[k2*3] = win[k2*3+1];
					win[k2*3+1] = win[k2*3+2];
				end
				win[2] = up;
				win[5] = mid;
				win[8] = cur;
				last = (c + 1 >= w);
				if (row_cnt >= 1) begin
					if (c >= 1) from_window(c >= 2 ? 0 : 1, 1, 2);
					if (last) from_window(c >= 1 ? 1 : 2, 2, 2);
				end
				if (last) begin
					col_cnt = 0;
					row_cnt++;
				end else begin
					col_cnt = c + 1;
				end
				return;
			end
			if (row_cnt < h) return;
			k = drain_cnt % 1024;
			l = (k > 0) ? k - 1 : k;
			rr = (k + 1 < w) ? k + 1 : k;
			last = (k + 1 >= w);
			p[0] = upper_row[l];  p[1] = upper_row[k];  p[2] = upper_row[rr];
			p[3] = middle_row[l]; p[4] = middle_row[k]; p[5] = middle_row[rr];
			p[6] = middle_row[l]; p[7] = middle_row[k]; p[8] = middle_row[rr];
			expected_pix.push_back(convolve(p, last));
			if (last) begin
				row_cnt = 0;
				col_cnt = 0;
				drain_cnt = 0;
			end else begin
				drain_cnt = k + 1;
			end
		endfunction

		function void check_result(filt_pix_t got);
			filt_pix_t exp_pix;
			if (expected_pix.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			exp_pix = expected_pix.pop_front();
			if (got !== exp_pix) begin
				mismatches++;
				if (mismatches <= 10)
					$display("expected r%0d g%0d b%0d a%0d e%0d, got r%0d g%0d b%0d a%0d e%0d",
						exp_pix.red, exp_pix.green, exp_pix.blue, exp_pix.alpha,
						exp_pix.frame_end, got.red, got.green, got.blue, got.alpha,
						got.frame_end);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;
	bit          gaps_on;
	int unsigned pushes_sent;
	conv_scoreboard sb;

	rgbc_in_if  in_ch();
	rgbc_out_if out_ch();

	rgb_conv3x3_replicate_edge dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_in(in_ch),
		.pix_out(out_ch)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			sb.note_request(in_ch.operation, in_ch.in_red, in_ch.in_green,
				in_ch.in_blue, in_ch.in_alpha);
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result({out_ch.out_red, out_ch.out_green, out_ch.out_blue,
				out_ch.out_alpha, out_ch.frame_end});
		out_ch.ready <= gaps_on ? ($urandom_range(99) >= 17) : 1'b1;
	end

	function automatic logic [7:0] pick_byte();
		int unsigned sel;
		sel = $urandom_range(19);
		if (sel == 0) return 8'd0;
		if (sel == 1) return 8'd255;
		return 8'($urandom);
	endfunction

	task automatic send_request(logic op, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [7:0] a);
		while (gaps_on && $urandom_range(99) < 17) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.in_red <= r;
		in_ch.in_green <= g;
		in_ch.in_blue <= b;
		in_ch.in_alpha <= a;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_pix.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(int unsigned w, int unsigned h, logic [47:0] kt,
			logic [47:0] km, logic [47:0] kb);
		logic [47:0] vals[5];
		vals = '{48'(w), 48'(h), kt, km, kb};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			sb.write_reg(3'(i), vals[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [47:0] rand_kernel_row();
		logic [47:0] row;
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(7))
				0: row[16*i +: 16] = 16'h7FFF;
				1: row[16*i +: 16] = 16'h8000;
				2: row[16*i +: 16] = 16'h0000;
				3, 4: row[16*i +: 16] = 16'($urandom);
				default: row[16*i +: 16] = 16'($signed($urandom_range(8192)) - 4096);
			endcase
		end
		return row;
	endfunction

	// noise: early drains inside the frame, surplus pushes before the drain
	task automatic run_frame(int unsigned w, int unsigned h, bit noise);
		for (int unsigned i = 0; i < w * h; i++) begin
			if (noise && $urandom_range(99) < 3)
				send_request(rgbc_pkg::OP_DRAIN, pick_byte(), pick_byte(), pick_byte(),
					pick_byte());
			send_request(rgbc_pkg::OP_PUSH, pick_byte(), pick_byte(), pick_byte(),
				pick_byte());
			pushes_sent++;
		end
		if (noise && $urandom_range(99) < 30)
			send_request(rgbc_pkg::OP_PUSH, pick_byte(), pick_byte(), pick_byte(),
				pick_byte());
		for (int unsigned i = 0; i < w; i++)
			send_request(rgbc_pkg::OP_DRAIN, pick_byte(), pick_byte(), pick_byte(),
				pick_byte());
		wait_drained();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = rgbc_pkg::CFG_WIDTH;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.operation = rgbc_pkg::OP_PUSH;
		in_ch.in_red = '0;
		in_ch.in_green = '0;
		in_ch.in_blue = '0;
		in_ch.in_alpha = '0;
		out_ch.ready = 1'b0;
		gaps_on = 1'b1;
		pushes_sent = 0;
		sb = new();
		sb.reset_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_regs(3, 3, 48'd0, 48'd268435456, 48'd0);
		run_frame(3, 3, 1'b0);
		write_regs(1, 1, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
		send_request(rgbc_pkg::OP_DRAIN, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		run_frame(1, 1, 1'b0);
		write_regs(2, 2, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
		run_frame(2, 2, 1'b1);
		write_regs(4, 3, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
		run_frame(4, 3, 1'b1);
		write_regs(300, 1, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
		run_frame(300, 1, 1'b0);
		write_regs(1, 200, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
		run_frame(1, 200, 1'b0);

		pushes_sent = 0;
		while (pushes_sent < 900) begin
			gaps_on = !(pushes_sent > 300 && pushes_sent < 600);
			write_regs($urandom_range(1, 16), $urandom_range(1, 10), rand_kernel_row(),
				rand_kernel_row(), rand_kernel_row());
			run_frame(sb.width_reg, sb.height_reg, 1'b1);
		end
		gaps_on = 1'b1;
		wait_drained();
		sb.mismatches += sb.expected_pix.size();
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/rgbc_pkg.sv
rtl/core/rgbc_if.sv
rtl/core/rgbc_linebuf.sv
rtl/core/rgb_conv3x3_replicate_edge.sv
tb/rgb_conv3x3_replicate_edge_tb.sv
